[design/assert_macros.svh]
// Assertion helpers used by the sequencer
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS
// Clocked check, masked while reset is held
`define TWS_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("tws check failed");
// Clocked check, live during reset too
`define TWS_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) (prop)) \
    else $error("tws check failed");
`else
`define TWS_ASSERT(lbl, clk, rst_n, prop)
`define TWS_ASSERT_ALWAYS(lbl, clk, prop)
`endif

`endif

[design/tws_pkg.sv]
package tws_pkg;

  // Opcodes of an input word
  localparam logic [1:0] OP_TICK  = 2'd0;
  localparam logic [1:0] OP_WRITE = 2'd1;
  localparam logic [1:0] OP_READ  = 2'd2;

  // Configuration register indexes
  localparam logic [1:0] CFG_HALF_PERIOD = 2'd0;
  localparam logic [1:0] CFG_RESET_PAUSE = 2'd1;
  localparam logic [1:0] CFG_MAX_RETRIES = 2'd2;

  // Reset values of the configuration registers
  localparam logic [15:0] HALF_PERIOD_RST = 16'd5;
  localparam logic [15:0] RESET_PAUSE_RST = 16'd50;
  localparam logic [2:0]  MAX_RETRIES_RST = 3'd3;

  // Address byte
  localparam int unsigned ADDR_BITS = 8;
  localparam logic [7:0]  READ_FLAG = 8'h80;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [6:0]  reg_addr;
    logic [15:0] write_data;
    logic        sda_in;
  } in_item_t;

  typedef struct packed {
    logic        chip_select_n;
    logic        serial_clock;
    logic        data_out;
    logic        data_drive;
    logic        busy_res;
    logic        done_res;
    logic [15:0] read_data;
    logic        stuck;
    logic [2:0]  retries_used;
    logic        rejected;
  } out_item_t;

  typedef struct packed {
    logic [1:0]  reg_index;
    logic [15:0] wr_data;
  } cfg_word_t;

  typedef struct packed {
    logic [15:0] half_period_ticks;
    logic [15:0] reset_pause_ticks;
    logic [2:0]  max_retries;
  } cfg_regs_t;

endpackage

[design/tws_chan_if.sv]
// Valid/ready channel carrying one word per handshake
interface tws_chan_if #(
  parameter type payload_t = logic
) ();
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

[design/tws_cfg_regs.sv]
// Configuration register file, written through its own channel
module tws_cfg_regs (
  input  logic               clk,
  input  logic               rst_n,
  tws_chan_if.sink           cfg_if,
  output tws_pkg::cfg_regs_t regs
);

  tws_pkg::cfg_regs_t regs_r;
  logic               wr_en;

  // Always able to take a write
  assign cfg_if.ready = 1'b1;
  assign wr_en        = cfg_if.valid;
  assign regs         = regs_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      regs_r.half_period_ticks <= tws_pkg::HALF_PERIOD_RST;
      regs_r.reset_pause_ticks <= tws_pkg::RESET_PAUSE_RST;
      regs_r.max_retries       <= tws_pkg::MAX_RETRIES_RST;
    end else if (wr_en) begin
      case (cfg_if.data.reg_index)
        tws_pkg::CFG_HALF_PERIOD: regs_r.half_period_ticks <= cfg_if.data.wr_data;
        tws_pkg::CFG_RESET_PAUSE: regs_r.reset_pause_ticks <= cfg_if.data.wr_data;
        tws_pkg::CFG_MAX_RETRIES: regs_r.max_retries       <= cfg_if.data.wr_data[2:0];
        default: ;
      endcase
    end
  end

endmodule

[design/tws_seq.sv]
`include "assert_macros.svh"

// Bus sequencer: one tick per accepted word, next state and result word
// formed combinationally from the current state, the word and the config.
module tws_seq #(
  parameter int unsigned DATA_BITS = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               accept,
  input  tws_pkg::in_item_t  item,
  input  tws_pkg::cfg_regs_t regs,
  output tws_pkg::out_item_t result
);

  localparam int unsigned SO_W  = tws_pkg::ADDR_BITS + DATA_BITS;
  localparam int unsigned IDX_W = $clog2(SO_W);
  localparam int unsigned BC_W  = $clog2(SO_W + 1);

  localparam logic [3:0] PH_IDLE   = 4'd0;
  localparam logic [3:0] PH_SETUP  = 4'd1;
  localparam logic [3:0] PH_LOW    = 4'd2;
  localparam logic [3:0] PH_HIGH   = 4'd3;
  localparam logic [3:0] PH_TURN1  = 4'd4;
  localparam logic [3:0] PH_TURN2  = 4'd5;
  localparam logic [3:0] PH_RHIGH  = 4'd6;
  localparam logic [3:0] PH_RLOW   = 4'd7;
  localparam logic [3:0] PH_END    = 4'd8;
  localparam logic [3:0] PH_BUSRST = 4'd9;

  logic [3:0]           phase_r, phase_nxt;
  logic [BC_W-1:0]      bit_cnt_r, bit_cnt_nxt;
  logic [SO_W-1:0]      shift_out_r, shift_out_nxt;
  logic [DATA_BITS-1:0] shift_in_r, shift_in_nxt;
  logic [15:0]          wait_r, wait_nxt;
  logic [2:0]           retry_r, retry_nxt;
  logic                 is_read_r, is_read_nxt;
  logic [15:0]          last_read_r, last_read_nxt;
  logic                 last_stuck_r, last_stuck_nxt;
  logic [2:0]           last_retries_r, last_retries_nxt;
  logic                 cs_r, cs_nxt;
  logic                 sck_r, sck_nxt;
  logic                 sda_r, sda_nxt;
  logic                 drive_r, drive_nxt;

  logic                 is_cmd;
  logic                 done;
  logic                 rejected;
  logic                 bad;
  logic [15:0]          half;
  logic [15:0]          pause;
  logic [15:0]          wait_dec;
  logic [BC_W-1:0]      bc_inc;
  logic [BC_W-1:0]      bc_sel;
  logic [BC_W-1:0]      out_total;
  logic [IDX_W-1:0]     bit_idx;
  logic                 tx_bit;

  // Zero delays count as one tick
  assign half  = (regs.half_period_ticks == 16'd0) ? 16'd1 : regs.half_period_ticks;
  assign pause = (regs.reset_pause_ticks == 16'd0) ? 16'd1 : regs.reset_pause_ticks;

  assign is_cmd    = (item.opcode == tws_pkg::OP_WRITE) || (item.opcode == tws_pkg::OP_READ);
  assign bc_inc    = bit_cnt_r + BC_W'(1);
  assign out_total = is_read_r ? BC_W'(tws_pkg::ADDR_BITS) : BC_W'(SO_W);
  assign wait_dec  = (wait_r != 16'd0) ? (wait_r - 16'd1) : wait_r;
  assign bad       = (shift_in_r == '0) || (&shift_in_r);

  // Outgoing bit: the frame sits MSB-aligned, so bit n lies at SO_W-1-n
  assign bc_sel  = (phase_r == PH_HIGH) ? bc_inc : bit_cnt_r;
  assign bit_idx = IDX_W'(SO_W - 1) - bc_sel[IDX_W-1:0];
  assign tx_bit  = shift_out_r[bit_idx];

  // Next state for one tick
  always_comb begin
    phase_nxt        = phase_r;
    bit_cnt_nxt      = bit_cnt_r;
    shift_out_nxt    = shift_out_r;
    shift_in_nxt     = shift_in_r;
    wait_nxt         = wait_r;
    retry_nxt        = retry_r;
    is_read_nxt      = is_read_r;
    last_read_nxt    = last_read_r;
    last_stuck_nxt   = last_stuck_r;
    last_retries_nxt = last_retries_r;
    cs_nxt           = cs_r;
    sck_nxt          = sck_r;
    sda_nxt          = sda_r;
    drive_nxt        = drive_r;
    done             = 1'b0;
    rejected         = 1'b0;

    if (phase_r != PH_IDLE) begin
      rejected = is_cmd;
      wait_nxt = wait_dec;
      if (wait_dec == 16'd0) begin
        case (phase_r)
          PH_SETUP: begin
            sck_nxt   = 1'b0;
            drive_nxt = 1'b1;
            sda_nxt   = tx_bit;
            phase_nxt = PH_LOW;
            wait_nxt  = half;
          end
          PH_LOW: begin
            sck_nxt   = 1'b1;
            phase_nxt = PH_HIGH;
            wait_nxt  = half;
          end
          PH_HIGH: begin
            bit_cnt_nxt = bc_inc;
            wait_nxt    = half;
            if (bc_inc < out_total) begin
              sck_nxt   = 1'b0;
              drive_nxt = 1'b1;
              sda_nxt   = tx_bit;
              phase_nxt = PH_LOW;
            end else if (!is_read_r) begin
              cs_nxt    = 1'b1;
              phase_nxt = PH_END;
            end else begin
              sck_nxt   = 1'b0;
              phase_nxt = PH_TURN1;
            end
          end
          PH_TURN1: begin
            drive_nxt = 1'b0;
            sda_nxt   = 1'b1;
            phase_nxt = PH_TURN2;
            wait_nxt  = half;
          end
          PH_TURN2: begin
            bit_cnt_nxt = '0;
            sck_nxt     = 1'b1;
            phase_nxt   = PH_RHIGH;
            wait_nxt    = half;
          end
          PH_RHIGH: begin
            shift_in_nxt = {shift_in_r[DATA_BITS-2:0], item.sda_in};
            sck_nxt      = 1'b0;
            phase_nxt    = PH_RLOW;
            wait_nxt     = half;
          end
          PH_RLOW: begin
            bit_cnt_nxt = bc_inc;
            wait_nxt    = half;
            if (bc_inc < BC_W'(DATA_BITS)) begin
              sck_nxt   = 1'b1;
              phase_nxt = PH_RHIGH;
            end else begin
              cs_nxt    = 1'b1;
              phase_nxt = PH_END;
            end
          end
          PH_END: begin
            cs_nxt    = 1'b1;
            sck_nxt   = 1'b0;
            sda_nxt   = 1'b1;
            drive_nxt = 1'b1;
            if (is_read_r && bad && (retry_r < regs.max_retries)) begin
              // stuck line: idle the bus for a while, then try again
              retry_nxt = retry_r + 3'd1;
              phase_nxt = PH_BUSRST;
              wait_nxt  = pause;
            end else begin
              if (is_read_r) begin
                last_read_nxt    = 16'(shift_in_r);
                last_stuck_nxt   = bad;
                last_retries_nxt = retry_r;
              end
              phase_nxt = PH_IDLE;
              wait_nxt  = 16'd0;
              done      = 1'b1;
            end
          end
          PH_BUSRST: begin
            bit_cnt_nxt  = '0;
            shift_in_nxt = '0;
            cs_nxt       = 1'b0;
            sck_nxt      = 1'b0;
            drive_nxt    = 1'b1;
            sda_nxt      = 1'b1;
            phase_nxt    = PH_SETUP;
            wait_nxt     = half;
          end
          default: begin
            cs_nxt    = 1'b1;
            sck_nxt   = 1'b0;
            sda_nxt   = 1'b1;
            drive_nxt = 1'b1;
            phase_nxt = PH_IDLE;
            wait_nxt  = 16'd0;
          end
        endcase
      end
    end else if (is_cmd) begin
      // New transaction: load the frame and start the setup delay
      is_read_nxt = (item.opcode == tws_pkg::OP_READ);
      if (item.opcode == tws_pkg::OP_READ) begin
        shift_out_nxt = {({1'b0, item.reg_addr} | tws_pkg::READ_FLAG), {DATA_BITS{1'b0}}};
        retry_nxt     = 3'd0;
      end else begin
        shift_out_nxt = {1'b0, item.reg_addr, DATA_BITS'(item.write_data)};
      end
      bit_cnt_nxt  = '0;
      shift_in_nxt = '0;
      cs_nxt       = 1'b0;
      sck_nxt      = 1'b0;
      drive_nxt    = 1'b1;
      sda_nxt      = 1'b1;
      phase_nxt    = PH_SETUP;
      wait_nxt     = half;
    end
  end

  // Result word for this tick
  always_comb begin
    result.chip_select_n = cs_nxt;
    result.serial_clock  = sck_nxt;
    result.data_out      = drive_nxt ? sda_nxt : 1'b1;
    result.data_drive    = drive_nxt;
    result.busy_res      = (phase_nxt != PH_IDLE);
    result.done_res      = done;
    result.read_data     = last_read_nxt;
    result.stuck         = last_stuck_nxt;
    result.retries_used  = last_retries_nxt;
    result.rejected      = rejected;
  end

  // State registers, advanced once per accepted word
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r        <= PH_IDLE;
      bit_cnt_r      <= '0;
      shift_out_r    <= '0;
      shift_in_r     <= '0;
      wait_r         <= 16'd0;
      retry_r        <= 3'd0;
      is_read_r      <= 1'b0;
      last_read_r    <= 16'd0;
      last_stuck_r   <= 1'b0;
      last_retries_r <= 3'd0;
      cs_r           <= 1'b1;
      sck_r          <= 1'b0;
      sda_r          <= 1'b1;
      drive_r        <= 1'b1;
    end else if (accept) begin
      phase_r        <= phase_nxt;
      bit_cnt_r      <= bit_cnt_nxt;
      shift_out_r    <= shift_out_nxt;
      shift_in_r     <= shift_in_nxt;
      wait_r         <= wait_nxt;
      retry_r        <= retry_nxt;
      is_read_r      <= is_read_nxt;
      last_read_r    <= last_read_nxt;
      last_stuck_r   <= last_stuck_nxt;
      last_retries_r <= last_retries_nxt;
      cs_r           <= cs_nxt;
      sck_r          <= sck_nxt;
      sda_r          <= sda_nxt;
      drive_r        <= drive_nxt;
    end
  end

  // SDA is only released during a read
  `TWS_ASSERT(a_release_only_read, clk, rst_n, !drive_r |-> is_read_r)
  // A busy phase always has a tick left to count
  `TWS_ASSERT(a_busy_wait, clk, rst_n, (phase_r != PH_IDLE) |-> (wait_r != 16'd0))
  // Idle means idle bus levels
  `TWS_ASSERT(a_idle_lines, clk, rst_n,
    (phase_r == PH_IDLE) |-> (cs_r && !sck_r && drive_r && sda_r))
  // A completion always lands in idle
  `TWS_ASSERT(a_done_idle, clk, rst_n, (accept && done) |=> (phase_r == PH_IDLE))

endmodule

[design/tws_out_reg.sv]
// Result register: holds one word until the sink takes it
module tws_out_reg (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               load,
  input  tws_pkg::out_item_t word_in,
  output logic               can_load,
  tws_chan_if.source         out_if
);

  logic               valid_r;
  tws_pkg::out_item_t word_r;

  // Room when empty or when the held word leaves this cycle
  assign can_load     = !valid_r || out_if.ready;
  assign out_if.valid = valid_r;
  assign out_if.data  = word_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (load) begin
      valid_r <= 1'b1;
    end else if (out_if.ready) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      word_r <= word_in;
    end
  end

endmodule

[design/three_wire_spi_register_master.sv]
// Three-wire SPI register master. Every input word is one tick of the bus
// timebase and yields exactly one result word with the bus line levels and
// status after that tick. A word is taken every clock cycle while in_if.ready
// is high: the sequencer state moves on the edge a word is accepted, and the
// result word is caught in an output register on that same edge, so it is
// offered from the next cycle. in_if.ready only drops while that register is
// full and out_if.ready is low. SCK timing is counted in ticks
// (half_period_ticks per half period, reset_pause_ticks per bus reset), not
// in clock cycles. Configuration words are taken at any time but should only
// be written while no transaction is running.
module three_wire_spi_register_master #(
  parameter int unsigned DATA_BITS = 16
) (
  input  logic       clk,
  input  logic       rst_n,
  tws_chan_if.sink   in_if,
  tws_chan_if.source out_if,
  tws_chan_if.sink   cfg_if
);

  tws_pkg::cfg_regs_t regs;
  tws_pkg::out_item_t result;
  logic               can_load;
  logic               accept;

  assign in_if.ready = can_load;
  assign accept      = in_if.valid && can_load;

  tws_cfg_regs u_cfg (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg_if (cfg_if),
    .regs   (regs)
  );

  tws_seq #(
    .DATA_BITS (DATA_BITS)
  ) u_seq (
    .clk    (clk),
    .rst_n  (rst_n),
    .accept (accept),
    .item   (in_if.data),
    .regs   (regs),
    .result (result)
  );

  tws_out_reg u_out (
    .clk      (clk),
    .rst_n    (rst_n),
    .load     (accept),
    .word_in  (result),
    .can_load (can_load),
    .out_if   (out_if)
  );

endmodule

[bench/tb.sv]
`timescale 1ns / 1ps

module tb;

  localparam int unsigned DATA_W         = 16;
  localparam int unsigned RESET_CYCLES   = 9;
  localparam int unsigned WATCHDOG_LIMIT = 2000;
  localparam int unsigned LONG_HOLD      = 300;
  localparam int unsigned TAIL_CYCLES    = 20;
  localparam int unsigned MAX_PRINTS     = 100;

  // Opcode 3 is not decoded and behaves as a plain tick
  localparam logic [1:0] OP_SPARE = 2'd3;

  // Sequencer phases of the bus master
  localparam logic [3:0] SQ_IDLE   = 4'd0;
  localparam logic [3:0] SQ_SETUP  = 4'd1;
  localparam logic [3:0] SQ_LOW    = 4'd2;
  localparam logic [3:0] SQ_HIGH   = 4'd3;
  localparam logic [3:0] SQ_TURN1  = 4'd4;
  localparam logic [3:0] SQ_TURN2  = 4'd5;
  localparam logic [3:0] SQ_RHIGH  = 4'd6;
  localparam logic [3:0] SQ_RLOW   = 4'd7;
  localparam logic [3:0] SQ_END    = 4'd8;
  localparam logic [3:0] SQ_BUSRST = 4'd9;

  // Read value presented on SDA for each attempt of one read
  typedef logic [15:0] attempt_vals_t [8];

  logic clk = 1'b0;
  logic rst_n;

  tws_chan_if #(.payload_t(tws_pkg::in_item_t))  in_if ();
  tws_chan_if #(.payload_t(tws_pkg::out_item_t)) out_if ();
  tws_chan_if #(.payload_t(tws_pkg::cfg_word_t)) cfg_if ();

  three_wire_spi_register_master #(.DATA_BITS(DATA_W)) u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_if),
    .out_if (out_if),
    .cfg_if (cfg_if)
  );

  always #5 clk = ~clk;

  wire in_acc  = in_if.valid && in_if.ready;
  wire out_acc = out_if.valid && out_if.ready;
  wire cfg_acc = cfg_if.valid && cfg_if.ready;

  // Words waiting to be sent, and status words still to arrive
  tws_pkg::in_item_t  tick_backlog[$];
  tws_pkg::out_item_t expected_status[$];

  int unsigned err_count      = 0;
  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned hold_left      = 0;
  int unsigned stray_pct      = 0;
  int unsigned late_pct       = 0;

  // Bus master model: configuration, sequencer state, line levels
  logic [15:0] sq_half, sq_pause;
  logic [2:0]  sq_retry_max;
  logic [3:0]  sq_phase;
  logic [4:0]  sq_bits;
  logic [23:0] sq_tx;
  logic [15:0] sq_rx;
  logic [15:0] sq_wait;
  logic [2:0]  sq_tries;
  logic        sq_rd;
  logic [15:0] sq_last;
  logic        sq_last_stuck;
  logic [2:0]  sq_last_tries;
  logic        ln_cs, ln_sck, ln_sda, ln_drv;

  function automatic logic [15:0] at_least_one(logic [15:0] n);
    return (n == 16'd0) ? 16'd1 : n;
  endfunction

  function automatic logic is_flat(logic [15:0] v);
    return (v == 16'h0000) || (v == 16'hFFFF);
  endfunction

  function automatic void sq_enter(logic [3:0] ph, logic [15:0] ticks);
    sq_phase = ph;
    sq_wait  = at_least_one(ticks);
  endfunction

  function automatic void lines_to_idle();
    ln_cs  = 1'b1;
    ln_sck = 1'b0;
    ln_sda = 1'b1;
    ln_drv = 1'b1;
  endfunction

  function automatic int unsigned tx_bits();
    return sq_rd ? tws_pkg::ADDR_BITS : tws_pkg::ADDR_BITS + DATA_W;
  endfunction

  // Put the next outgoing bit on SDA with SCK low, MSB first
  function automatic void put_bit();
    int unsigned pos;
    pos    = tx_bits() - 1 - sq_bits;
    ln_sck = 1'b0;
    ln_drv = 1'b1;
    ln_sda = sq_tx[pos];
  endfunction

  function automatic void begin_attempt();
    sq_bits = '0;
    sq_rx   = '0;
    ln_cs   = 1'b0;
    ln_sck  = 1'b0;
    ln_drv  = 1'b1;
    ln_sda  = 1'b1;
    sq_enter(SQ_SETUP, sq_half);
  endfunction

  // Leave the current phase; high when the transfer completes
  function automatic logic sq_advance(logic sda);
    logic bad;
    case (sq_phase)
      SQ_SETUP: begin
        put_bit();
        sq_enter(SQ_LOW, sq_half);
      end
      SQ_LOW: begin
        ln_sck = 1'b1;
        sq_enter(SQ_HIGH, sq_half);
      end
      SQ_HIGH: begin
        sq_bits = sq_bits + 5'd1;
        if (sq_bits < tx_bits()) begin
          put_bit();
          sq_enter(SQ_LOW, sq_half);
        end else if (!sq_rd) begin
          ln_cs = 1'b1;
          sq_enter(SQ_END, sq_half);
        end else begin
          ln_sck = 1'b0;
          sq_enter(SQ_TURN1, sq_half);
        end
      end
      SQ_TURN1: begin
        ln_drv = 1'b0;
        ln_sda = 1'b1;
        sq_enter(SQ_TURN2, sq_half);
      end
      SQ_TURN2: begin
        sq_bits = '0;
        ln_sck  = 1'b1;
        sq_enter(SQ_RHIGH, sq_half);
      end
      SQ_RHIGH: begin
        sq_rx  = {sq_rx[14:0], sda};
        ln_sck = 1'b0;
        sq_enter(SQ_RLOW, sq_half);
      end
      SQ_RLOW: begin
        sq_bits = sq_bits + 5'd1;
        if (sq_bits < DATA_W) begin
          ln_sck = 1'b1;
          sq_enter(SQ_RHIGH, sq_half);
        end else begin
          ln_cs = 1'b1;
          sq_enter(SQ_END, sq_half);
        end
      end
      SQ_END: begin
        if (sq_rd) begin
          bad = is_flat(sq_rx);
          // stuck read with retries left: reset the bus and go again
          if (bad && sq_tries < sq_retry_max) begin
            sq_tries = sq_tries + 3'd1;
            lines_to_idle();
            sq_enter(SQ_BUSRST, sq_pause);
            return 1'b0;
          end
          sq_last       = sq_rx;
          sq_last_stuck = bad;
          sq_last_tries = sq_tries;
        end
        lines_to_idle();
        sq_phase = SQ_IDLE;
        sq_wait  = '0;
        return 1'b1;
      end
      SQ_BUSRST: begin_attempt();
      default: begin
        lines_to_idle();
        sq_phase = SQ_IDLE;
        sq_wait  = '0;
      end
    endcase
    return 1'b0;
  endfunction

  function automatic void spi_reset();
    sq_half       = tws_pkg::HALF_PERIOD_RST;
    sq_pause      = tws_pkg::RESET_PAUSE_RST;
    sq_retry_max  = tws_pkg::MAX_RETRIES_RST;
    sq_phase      = SQ_IDLE;
    sq_bits       = '0;
    sq_tx         = '0;
    sq_rx         = '0;
    sq_wait       = '0;
    sq_tries      = '0;
    sq_rd         = 1'b0;
    sq_last       = '0;
    sq_last_stuck = 1'b0;
    sq_last_tries = '0;
    lines_to_idle();
  endfunction

  function automatic void spi_cfg(logic [1:0] idx, logic [15:0] val);
    case (idx)
      tws_pkg::CFG_HALF_PERIOD: sq_half = val;
      tws_pkg::CFG_RESET_PAUSE: sq_pause = val;
      tws_pkg::CFG_MAX_RETRIES: sq_retry_max = val[2:0];
      default: ;
    endcase
  endfunction

  // One timebase tick: returns the status word it should produce
  function automatic tws_pkg::out_item_t spi_tick(tws_pkg::in_item_t w);
    tws_pkg::out_item_t r;
    logic cmd, done, rej;
    cmd  = (w.opcode == tws_pkg::OP_WRITE) || (w.opcode == tws_pkg::OP_READ);
    done = 1'b0;
    rej  = 1'b0;
    if (sq_phase != SQ_IDLE) begin
      // commands are refused while busy, completion tick included
      rej = cmd;
      if (sq_wait != 16'd0) sq_wait = sq_wait - 16'd1;
      if (sq_wait == 16'd0) done = sq_advance(w.sda_in);
    end else if (cmd) begin
      sq_rd = (w.opcode == tws_pkg::OP_READ);
      if (sq_rd) begin
        sq_tx    = {16'h0000, tws_pkg::READ_FLAG | {1'b0, w.reg_addr}};
        sq_tries = '0;
      end else begin
        sq_tx = {1'b0, w.reg_addr, w.write_data};
      end
      begin_attempt();
    end
    r.chip_select_n = ln_cs;
    r.serial_clock  = ln_sck;
    r.data_out      = ln_drv ? ln_sda : 1'b1;
    r.data_drive    = ln_drv;
    r.busy_res      = (sq_phase != SQ_IDLE);
    r.done_res      = done;
    r.read_data     = sq_last;
    r.stuck         = sq_last_stuck;
    r.retries_used  = sq_last_tries;
    r.rejected      = rej;
    return r;
  endfunction

  task automatic report_error(string msg);
    if (err_count < MAX_PRINTS) $display("ERROR @%0t: %s", $time, msg);
    err_count++;
  endtask

  task automatic check_status(tws_pkg::out_item_t got, tws_pkg::out_item_t want);
    string bad_fields;
    bad_fields = "";
    if (got.chip_select_n !== want.chip_select_n) bad_fields = {bad_fields, " chip_select_n"};
    if (got.serial_clock !== want.serial_clock)   bad_fields = {bad_fields, " serial_clock"};
    if (got.data_out !== want.data_out)           bad_fields = {bad_fields, " data_out"};
    if (got.data_drive !== want.data_drive)       bad_fields = {bad_fields, " data_drive"};
    if (got.busy_res !== want.busy_res)           bad_fields = {bad_fields, " busy_res"};
    if (got.done_res !== want.done_res)           bad_fields = {bad_fields, " done_res"};
    if (got.read_data !== want.read_data)         bad_fields = {bad_fields, " read_data"};
    if (got.stuck !== want.stuck)                 bad_fields = {bad_fields, " stuck"};
    if (got.retries_used !== want.retries_used)   bad_fields = {bad_fields, " retries_used"};
    if (got.rejected !== want.rejected)           bad_fields = {bad_fields, " rejected"};
    if (bad_fields != "")
      report_error($sformatf("status word mismatch:%s got %h want %h",
                             bad_fields, got, want));
  endtask

  // Driver: offers queued words, predicts each one on acceptance
  always @(posedge clk) begin
    if (!rst_n) begin
      in_if.valid <= 1'b0;
    end else begin
      if (in_acc) expected_status.push_back(spi_tick(in_if.data));
      if (!in_if.valid || in_if.ready) begin
        if (tick_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          in_if.data  <= tick_backlog.pop_front();
          in_if.valid <= 1'b1;
        end else begin
          in_if.valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: checks status words in order, drives out ready
  always @(posedge clk) begin
    if (!rst_n) begin
      out_if.ready <= 1'b0;
    end else begin
      if (out_acc) begin
        if (expected_status.size() == 0) report_error("status word with nothing expected");
        else check_status(out_if.data, expected_status.pop_front());
      end
      if (hold_left != 0) begin
        out_if.ready <= 1'b0;
        hold_left    <= hold_left - 1;
      end else begin
        out_if.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // Watchdog: too long without any word moving on any channel
  initial begin : watchdog
    int unsigned stale;
    stale = 0;
    while (stale < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if (rst_n && !(in_acc || out_acc || cfg_acc)) stale++;
      else stale = 0;
    end
    $display("tb failed");
    $finish;
  end

  // Stimulus helpers
  function automatic tws_pkg::in_item_t any_word(logic [1:0] op);
    tws_pkg::in_item_t w;
    w.opcode     = op;
    w.reg_addr   = 7'($urandom_range(127));
    w.write_data = 16'($urandom);
    w.sda_in     = 1'($urandom);
    return w;
  endfunction

  function automatic void push_idle();
    tick_backlog.push_back(any_word($urandom_range(1) ? OP_SPARE : tws_pkg::OP_TICK));
  endfunction

  // Filler tick during a transfer, now and then a stray command
  function automatic void push_busy(int unsigned pct, logic sda);
    tws_pkg::in_item_t w;
    if ($urandom_range(99) < pct)
      w = any_word($urandom_range(1) ? tws_pkg::OP_READ : tws_pkg::OP_WRITE);
    else w = any_word($urandom_range(1) ? OP_SPARE : tws_pkg::OP_TICK);
    w.sda_in = sda;
    tick_backlog.push_back(w);
  endfunction

  function automatic logic [15:0] read_pattern();
    case ($urandom_range(5))
      0: return 16'h0000;
      1: return 16'hFFFF;
      2: return 16'h0001;
      3: return 16'hFFFE;
      default: return 16'($urandom);
    endcase
  endfunction

  // Write command plus the ticks it needs: setup, 24 bits, end delay
  task automatic send_write(logic [6:0] addr, logic [15:0] data);
    tws_pkg::in_item_t w;
    int unsigned n, t;
    w            = any_word(tws_pkg::OP_WRITE);
    w.reg_addr   = addr;
    w.write_data = data;
    tick_backlog.push_back(w);
    n = 50 * at_least_one(sq_half);
    for (t = 1; t <= n; t++) push_busy((t == n) ? late_pct : stray_pct, 1'($urandom));
  endtask

  // Read command; SDA carries vals[k] over the bit windows of attempt k.
  // One attempt: setup, 8 address bits, turnaround, 16 data bits, end delay.
  task automatic send_read(logic [6:0] addr, attempt_vals_t vals);
    tws_pkg::in_item_t w;
    int unsigned h, span, retries, n, k, o, j, t;
    logic sda;
    h       = at_least_one(sq_half);
    span    = 52 * h + at_least_one(sq_pause);
    retries = 0;
    while (retries < sq_retry_max && is_flat(vals[retries])) retries++;
    n = retries * span + 52 * h;
    w          = any_word(tws_pkg::OP_READ);
    w.reg_addr = addr;
    tick_backlog.push_back(w);
    for (t = 1; t <= n; t++) begin
      k   = (t - 1) / span;
      o   = t - k * span;
      sda = 1'($urandom);
      if (o > 19 * h && o <= 51 * h) begin
        j   = (o - 19 * h - 1) / (2 * h);
        sda = vals[k][15 - j];
      end
      push_busy((t == n) ? late_pct : stray_pct, sda);
    end
  endtask

  task automatic random_read(logic flat_bias);
    attempt_vals_t vals;
    int unsigned i;
    for (i = 0; i < 8; i++) begin
      if (flat_bias && $urandom_range(9) < 7) vals[i] = $urandom_range(1) ? 16'hFFFF : 16'h0000;
      else vals[i] = read_pattern();
    end
    send_read(7'($urandom_range(127)), vals);
  endtask

  // Mostly complete transfers back to back, with stray commands mixed in
  task automatic random_traffic(int unsigned n_words);
    int unsigned base;
    logic [15:0] data;
    base = tick_backlog.size();
    while (tick_backlog.size() < base + n_words) begin
      case ($urandom_range(9))
        0, 1, 2, 3: begin
          case ($urandom_range(9))
            0: data = 16'h0000;
            1: data = 16'hFFFF;
            default: data = 16'($urandom);
          endcase
          send_write(7'($urandom_range(127)), data);
        end
        4, 5, 6: random_read(1'b1);
        default: random_read(1'b0);
      endcase
      repeat ($urandom_range(3)) push_idle();
    end
  endtask

  // Block until every queued word has been sent and answered
  task automatic wait_drain();
    do @(posedge clk);
    while (tick_backlog.size() != 0 || in_if.valid || expected_status.size() != 0);
    @(negedge clk);
  endtask

  task automatic set_idling(int unsigned snd, int unsigned rcv);
    @(posedge clk);
    send_idle_pct  <= snd;
    recv_stall_pct <= rcv;
  endtask

  task automatic write_reg(logic [1:0] idx, logic [15:0] val);
    @(posedge clk);
    cfg_if.data  <= '{reg_index: idx, wr_data: val};
    cfg_if.valid <= 1'b1;
    @(posedge clk);
    while (!cfg_if.ready) @(posedge clk);
    spi_cfg(idx, val);
    cfg_if.valid <= 1'b0;
  endtask

  task automatic configure(logic [15:0] half, logic [15:0] pause, logic [2:0] retries);
    write_reg(tws_pkg::CFG_HALF_PERIOD, half);
    write_reg(tws_pkg::CFG_RESET_PAUSE, pause);
    write_reg(tws_pkg::CFG_MAX_RETRIES, {13'd0, retries});
  endtask

  // Main sequence
  initial begin
    int unsigned seg, i;
    in_if.valid  = 1'b0;
    in_if.data   = '0;
    out_if.ready = 1'b0;
    cfg_if.valid = 1'b0;
    cfg_if.data  = '0;
    rst_n        = 1'b0;
    spi_reset();
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    set_idling(0, 0);
    @(negedge clk);

    // Reset timing: idle ticks, then a full-scale write with occasional stray
    // commands mid transfer and one on the completing tick
    tick_backlog.push_back(any_word(tws_pkg::OP_TICK));
    tick_backlog.push_back(any_word(OP_SPARE));
    stray_pct = 2;
    late_pct  = 100;
    send_write(7'h7F, 16'hFFFF);
    stray_pct = 0;
    late_pct  = 0;
    wait_drain();

    // Stuck read, a retry that recovers, a near-flat read value
    configure(16'd1, 16'd2, 3'd1);
    send_read(7'h00, '{default: 16'h0000});
    send_read(7'h7F, '{0: 16'hFFFF, default: 16'h0001});
    send_read(7'h55, '{default: 16'hFFFE});
    wait_drain();

    // Zero half period acts as one; no retries allowed
    configure(16'd0, 16'd1, 3'd0);
    send_read(7'h01, '{default: 16'hFFFF});
    wait_drain();

    // Full retry budget with a zero bus reset pause: recovery on the last attempt
    configure(16'd1, 16'd0, 3'd7);
    send_read(7'h03, '{16'h0000, 16'hFFFF, 16'h0000, 16'hFFFF,
                       16'h0000, 16'hFFFF, 16'h0000, 16'h1234});
    wait_drain();

    // Random traffic over the idling mixes
    for (seg = 0; seg < 4; seg++) begin
      case (seg)
        0: set_idling(0, 0);
        1: set_idling(69, 0);
        2: set_idling(0, 69);
        default: set_idling(24, 24);
      endcase
      configure(16'($urandom_range(2, 1)), 16'($urandom_range(6, 1)),
                3'($urandom_range(3)));
      @(negedge clk);
      stray_pct = 3;
      late_pct  = 15;
      if (seg == 1) begin
        // sender pauses until the block has answered everything
        random_traffic(1);
        wait_drain();
        random_traffic(1);
      end else begin
        random_traffic(1);
      end
      if (seg == 0) begin
        // long receiver hold-off while the sender keeps offering
        @(posedge clk);
        hold_left <= LONG_HOLD;
      end
      wait_drain();
    end

    stray_pct = 0;
    late_pct  = 0;
    set_idling(0, 0);

    // Longest half period and pause, idle ticks only
    configure(16'hFFFF, 16'hFFFF, 3'd2);
    for (i = 0; i < 20; i++) push_idle();
    wait_drain();

    repeat (TAIL_CYCLES) @(posedge clk);
    if (expected_status.size() != 0)
      report_error($sformatf("%0d status words never arrived", expected_status.size()));
    if (err_count == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

endmodule
